// ----- rtl/arpc_pkg.sv -----
// Shared types, constants and helpers for the ARP cache lookup and learn block.
// Used by arpc_table, arpc_seq, arp_cache_lookup_learn and arpc_checker.
`default_nettype none

package arpc_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int IP_W     = 32;
   localparam int MAC_W    = 48;
   localparam int IDX_W    = 6;
   localparam int STATUS_W = 3;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_LEARN  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISS    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              key_wr_en;
      logic              val_wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [IP_W-1:0]   wr_key;
      logic [MAC_W-1:0]  wr_val;
   } tbl_req_type;

   typedef struct packed {
      logic [IP_W-1:0]  key;
      logic [MAC_W-1:0] val;
   } tbl_rd_type;

   // The reported entry index is the low bits of the table index.
   function automatic logic [IDX_W-1:0] entry_idx(input logic [CNT_W-1:0] v);
      return IDX_W'(v);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/arp_cache_lookup_learn.sv -----
// ARP cache with lookup and learn of IPv4-to-MAC pairs. One request is taken while the
// sequencer is idle; it then scans the filled entries through a single registered read
// port of the key and value memories, comparing one key per cycle, lowest index first.
// A key that matches no entry makes the scan read every filled entry; a match at index k
// ends the scan at that entry. The result goes to an output register, so the next
// request is taken while a result still waits for its transfer. Entries are appended in
// order and never removed; a learn with no free entry is dropped and reported as table
// full.
// Depends on arpc_pkg, arpc_seq and arpc_table.
`default_nettype none

module arp_cache_lookup_learn (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_opcode,
   input  logic [arpc_pkg::IP_W-1:0]      req_ip_address,
   input  logic [arpc_pkg::MAC_W-1:0]     req_mac_address,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [arpc_pkg::STATUS_W-1:0]  rsp_status,
   output logic [arpc_pkg::MAC_W-1:0]     rsp_found_mac,
   output logic [arpc_pkg::IDX_W-1:0]     rsp_entry_index
);

   arpc_pkg::tbl_req_type tbl_req;
   arpc_pkg::tbl_rd_type  tbl_rd;

   arpc_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_ip_address  (req_ip_address),
      .req_mac_address (req_mac_address),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_mac   (rsp_found_mac),
      .rsp_entry_index (rsp_entry_index),
      .tbl_req         (tbl_req),
      .tbl_rd          (tbl_rd)
   );

   arpc_table u_table (
      .clock   (clock),
      .tbl_req (tbl_req),
      .tbl_rd  (tbl_rd)
   );

endmodule

`default_nettype wire

// ----- rtl/arpc_table.sv -----
// Key and value memories of the ARP cache: one write port, one registered read port.
// Depends on arpc_pkg.
`default_nettype none

module arpc_table (
   input  logic                  clock,
   input  arpc_pkg::tbl_req_type tbl_req,
   output arpc_pkg::tbl_rd_type  tbl_rd
);

   logic [arpc_pkg::IP_W-1:0]  key_mem [arpc_pkg::TABLE_DEPTH];
   logic [arpc_pkg::MAC_W-1:0] val_mem [arpc_pkg::TABLE_DEPTH];
   arpc_pkg::tbl_rd_type       tbl_rd_ff;

   always_ff @(posedge clock) begin
      if (tbl_req.key_wr_en) begin
         key_mem[tbl_req.wr_addr] <= tbl_req.wr_key;
      end
      if (tbl_req.val_wr_en) begin
         val_mem[tbl_req.wr_addr] <= tbl_req.wr_val;
      end
      if (tbl_req.rd_en) begin
         tbl_rd_ff.key <= key_mem[tbl_req.rd_addr];
         tbl_rd_ff.val <= val_mem[tbl_req.rd_addr];
      end
   end

   assign tbl_rd = tbl_rd_ff;

endmodule

`default_nettype wire

// ----- rtl/arpc_seq.sv -----
// Search sequencer of the ARP cache: scans filled entries with one key comparator, then
// updates the table on a learn and loads the result register. Depends on arpc_pkg.
`default_nettype none

module arpc_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_opcode,
   input  logic [arpc_pkg::IP_W-1:0]      req_ip_address,
   input  logic [arpc_pkg::MAC_W-1:0]     req_mac_address,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [arpc_pkg::STATUS_W-1:0]  rsp_status,
   output logic [arpc_pkg::MAC_W-1:0]     rsp_found_mac,
   output logic [arpc_pkg::IDX_W-1:0]     rsp_entry_index,
   output arpc_pkg::tbl_req_type          tbl_req,
   input  arpc_pkg::tbl_rd_type           tbl_rd
);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_SCAN    = 2'd1;
   localparam logic [1:0] S_RESOLVE = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic                          op_ff, op_in;
   logic [arpc_pkg::IP_W-1:0]     ip_ff, ip_in;
   logic [arpc_pkg::MAC_W-1:0]    mac_ff, mac_in;
   logic [arpc_pkg::CNT_W-1:0]    scan_ff, scan_in;
   logic                          pend_ff, pend_in;
   logic [arpc_pkg::CNT_W-1:0]    pend_idx_ff, pend_idx_in;
   logic                          hit_ff, hit_in;
   logic [arpc_pkg::CNT_W-1:0]    hit_idx_ff, hit_idx_in;
   logic [arpc_pkg::MAC_W-1:0]    hit_val_ff, hit_val_in;
   logic [arpc_pkg::CNT_W-1:0]    filled_ff, filled_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [arpc_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [arpc_pkg::MAC_W-1:0]    rsp_mac_ff, rsp_mac_in;
   logic [arpc_pkg::IDX_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic                          key_match;

   assign key_match = pend_ff && (tbl_rd.key == ip_ff);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      ip_in         = ip_ff;
      mac_in        = mac_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_val_in    = hit_val_ff;
      filled_in     = filled_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_mac_in    = rsp_mac_ff;
      rsp_idx_in    = rsp_idx_ff;
      req_ready     = 1'b0;
      tbl_req       = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_opcode;
               ip_in    = req_ip_address;
               mac_in   = req_mac_address;
               scan_in  = '0;
               pend_in  = 1'b0;
               hit_in   = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (key_match) begin
               hit_in     = 1'b1;
               hit_idx_in = pend_idx_ff;
               hit_val_in = tbl_rd.val;
               pend_in    = 1'b0;
               state_in   = S_RESOLVE;
            end else if (scan_ff < filled_ff) begin
               tbl_req.rd_en   = 1'b1;
               tbl_req.rd_addr = scan_ff[arpc_pkg::ADDR_W-1:0];
               pend_in         = 1'b1;
               pend_idx_in     = scan_ff;
               scan_in         = arpc_pkg::CNT_W'(scan_ff + 1'b1);
            end else begin
               pend_in  = 1'b0;
               state_in = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_mac_in   = '0;
               rsp_idx_in   = '0;
               state_in     = S_IDLE;
               if (op_ff == arpc_pkg::OP_LOOKUP) begin
                  if (hit_ff) begin
                     rsp_status_in = arpc_pkg::ST_HIT;
                     rsp_mac_in    = hit_val_ff;
                     rsp_idx_in    = arpc_pkg::entry_idx(hit_idx_ff);
                  end else begin
                     rsp_status_in = arpc_pkg::ST_MISS;
                  end
               end else if (hit_ff) begin
                  tbl_req.val_wr_en = 1'b1;
                  tbl_req.wr_addr   = hit_idx_ff[arpc_pkg::ADDR_W-1:0];
                  tbl_req.wr_val    = mac_ff;
                  rsp_status_in     = arpc_pkg::ST_UPDATED;
                  rsp_idx_in        = arpc_pkg::entry_idx(hit_idx_ff);
               end else if (filled_ff < arpc_pkg::CNT_W'(arpc_pkg::TABLE_DEPTH)) begin
                  tbl_req.key_wr_en = 1'b1;
                  tbl_req.val_wr_en = 1'b1;
                  tbl_req.wr_addr   = filled_ff[arpc_pkg::ADDR_W-1:0];
                  tbl_req.wr_key    = ip_ff;
                  tbl_req.wr_val    = mac_ff;
                  filled_in         = arpc_pkg::CNT_W'(filled_ff + 1'b1);
                  rsp_status_in     = arpc_pkg::ST_ADDED;
                  rsp_idx_in        = arpc_pkg::entry_idx(filled_ff);
               end else begin
                  rsp_status_in = arpc_pkg::ST_FULL;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      ip_ff         <= ip_in;
      mac_ff        <= mac_in;
      scan_ff       <= scan_in;
      pend_idx_ff   <= pend_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_val_ff    <= hit_val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mac_ff    <= rsp_mac_in;
      rsp_idx_ff    <= rsp_idx_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_mac   = rsp_mac_ff;
   assign rsp_entry_index = rsp_idx_ff;

endmodule

`default_nettype wire

// ----- rtl/arpc_checker.sv -----
// Port-level assertions for arp_cache_lookup_learn and the bind that attaches them.
// Depends on arpc_pkg and the top-level port list.
`default_nettype none

module arpc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_opcode,
   input logic [arpc_pkg::IP_W-1:0]      req_ip_address,
   input logic [arpc_pkg::MAC_W-1:0]     req_mac_address,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [arpc_pkg::STATUS_W-1:0]  rsp_status,
   input logic [arpc_pkg::MAC_W-1:0]     rsp_found_mac,
   input logic [arpc_pkg::IDX_W-1:0]     rsp_entry_index
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_found_mac) && $stable(rsp_entry_index))
      else $error("Result changed before its transfer.");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Request taken while a search is in progress.");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= arpc_pkg::ST_FULL)
      else $error("Result status out of range.");

   a_mac_only_on_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != arpc_pkg::ST_HIT |-> rsp_found_mac == '0)
      else $error("Nonzero MAC reported without a hit.");

   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == arpc_pkg::ST_MISS || rsp_status == arpc_pkg::ST_FULL)
         |-> rsp_entry_index == '0)
      else $error("Nonzero entry index on a miss or a full table.");

endmodule

bind arp_cache_lookup_learn arpc_checker u_checker (.*);

`default_nettype wire
